>>> rtl/core/intel_hex_record_parser_defines.svh
// ----------------------------------------------------------------------------
// Intel HEX record parser assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_PARSER_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define IHEX_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent implies consequent at the next clock edge
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ihex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record parser package
// Parse phases, character constants and the hex digit decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_ADDR = 3'd2,
		PH_TYPE = 3'd3,
		PH_DATA = 3'd4,
		PH_CSUM = 3'd5
	} phase_t;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_END  = 1'b1
	} result_kind_t;

	localparam logic [7:0] COLON_CHAR = 8'h3A;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] UPPER_A    = 8'h41;
	localparam logic [7:0] UPPER_F    = 8'h46;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_F    = 8'h66;

	localparam int ADDR_W = 17;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		logic [7:0] off;
		d.ok = 1'b1;
		off  = '0;
		case (c) inside
			[ASCII_ZERO:ASCII_NINE]: off = c - ASCII_ZERO;
			[UPPER_A:UPPER_F]:       off = c - UPPER_A + 8'd10;
			[LOWER_A:LOWER_F]:       off = c - LOWER_A + 8'd10;
			default:                 d.ok = 1'b0;
		endcase
		d.val = off[3:0];
		return d;
	endfunction

endpackage

>>> rtl/core/intel_hex_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Decodes an Intel HEX character stream into data byte writes and record-end
// reports carrying the checksum verdict and the running address bounds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one text character per beat on character, taken at an edge
//   where in_valid is high and in_stall is low. Characters before a colon are
//   ignored; records of a type other than zero are dropped.
//   Output channel: at most one result per character. A data record gives one
//   write beat per data byte (result_kind 0, write_address, write_byte) and a
//   record-end beat after the checksum (result_kind 1, checksum_ok,
//   lowest_start, highest_end). Fields not used by a kind read as zero.
//   Order: a taken character waits in the input register, is parsed from it,
//   and its result is shown from the result register until it is taken.
//   Throughput: one character per cycle while out_stall holds no result, set by
//   the combinational state update between the input and result registers.
//   Stall: while out_stall holds a result, the input register waits and
//   in_stall rises only once it is full, so no beat is lost or repeated.
//   Reset: arst_n clears both registers and returns the parser to hunting for
//   a colon, with lowest_start tracking from one and highest_end from zero.
// ----------------------------------------------------------------------------
`include "intel_hex_record_parser_defines.svh"

module intel_hex_record_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   character,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         result_kind,
	output logic [ihex_pkg::ADDR_W-1:0]  write_address,
	output logic [7:0]                   write_byte,
	output logic                         checksum_ok,
	output logic [15:0]                  lowest_start,
	output logic [ihex_pkg::ADDR_W-1:0]  highest_end
);
	import ihex_pkg::*;

	// input register
	logic              valid_s1;
	logic [7:0]        char_s1;

	// parser state
	phase_t            phase_q, phase_d;
	logic [1:0]        digits_q, digits_d;
	logic [15:0]       accum_q, accum_d;
	logic              ended_q, ended_d;
	logic [7:0]        left_q, left_d;
	logic [ADDR_W-1:0] cursor_q, cursor_d;
	logic [15:0]       base_q, base_d;
	logic [7:0]        sum_q, sum_d;
	logic              start_q, start_d;
	logic [ADDR_W-1:0] end_q, end_d;

	// result register
	logic              out_valid_q;
	result_kind_t      kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        byte_q;
	logic              ok_q;
	logic              low_q;
	logic [ADDR_W-1:0] high_q;

	// combinational results
	logic              advance;
	logic              fire;
	hex_digit_t        hx;
	logic [2:0]        digits_inc;
	logic              done;
	logic [15:0]       accum_upd;
	logic              ended_upd;
	logic              res_valid;
	result_kind_t      res_kind;
	logic [ADDR_W-1:0] res_addr;
	logic [7:0]        res_byte;
	logic              res_ok;
	logic [7:0]        left_dec;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign hx         = hex_decode(char_s1);
	assign digits_inc = {1'b0, digits_q} + 3'd1;
	assign done       = (phase_q == PH_ADDR) ? (digits_inc == 3'd4) : (digits_inc >= 3'd2);
	// a non-hex character freezes the field value for the rest of its width
	assign accum_upd  = (!ended_q && hx.ok) ? {accum_q[11:0], hx.val} : accum_q;
	assign ended_upd  = ended_q || !hx.ok;
	assign left_dec   = left_q - 8'd1;

	always_comb begin
		phase_d   = phase_q;
		digits_d  = digits_q;
		accum_d   = accum_q;
		ended_d   = ended_q;
		left_d    = left_q;
		cursor_d  = cursor_q;
		base_d    = base_q;
		sum_d     = sum_q;
		start_d   = start_q;
		end_d     = end_q;
		res_valid = 1'b0;
		res_kind  = KIND_DATA;
		res_addr  = '0;
		res_byte  = '0;
		res_ok    = 1'b0;

		if (phase_q inside {PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM}) begin
			if (done) begin
				digits_d = '0;
				accum_d  = '0;
				ended_d  = 1'b0;
			end else begin
				digits_d = digits_inc[1:0];
				accum_d  = accum_upd;
				ended_d  = ended_upd;
			end
		end

		case (phase_q)
			PH_LEN: begin
				if (done) begin
					left_d  = accum_upd[7:0];
					sum_d   = accum_upd[7:0];
					phase_d = PH_ADDR;
				end
			end
			PH_ADDR: begin
				if (done) begin
					base_d   = accum_upd;
					cursor_d = {1'b0, accum_upd};
					sum_d    = sum_q + accum_upd[15:8] + accum_upd[7:0];
					phase_d  = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (done) begin
					sum_d = sum_q + accum_upd[7:0];
					if (accum_upd != '0) begin
						phase_d = PH_HUNT;
					end else if (left_q == '0) begin
						phase_d = PH_CSUM;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (done) begin
					res_valid = 1'b1;
					res_kind  = KIND_DATA;
					res_addr  = cursor_q;
					res_byte  = accum_upd[7:0];
					cursor_d  = cursor_q + ADDR_W'(1);
					sum_d     = sum_q + accum_upd[7:0];
					left_d    = left_dec;
					if (left_dec == '0) begin
						phase_d = PH_CSUM;
					end
				end
			end
			PH_CSUM: begin
				if (done) begin
					sum_d = sum_q + accum_upd[7:0];
					// lowest start begins at one, so only a zero base moves it
					if (base_q == '0) begin
						start_d = 1'b0;
					end
					if (end_q < cursor_q) begin
						end_d = cursor_q;
					end
					res_valid = 1'b1;
					res_kind  = KIND_END;
					res_ok    = (sum_d == '0);
					phase_d   = PH_HUNT;
				end
			end
			default: begin
				if (char_s1 == COLON_CHAR) begin
					digits_d = '0;
					accum_d  = '0;
					ended_d  = 1'b0;
					phase_d  = PH_LEN;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			char_s1 <= character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			digits_q <= '0;
			accum_q  <= '0;
			ended_q  <= 1'b0;
			left_q   <= '0;
			cursor_q <= '0;
			base_q   <= '0;
			sum_q    <= '0;
			start_q  <= 1'b1;
			end_q    <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			digits_q <= digits_d;
			accum_q  <= accum_d;
			ended_q  <= ended_d;
			left_q   <= left_d;
			cursor_q <= cursor_d;
			base_q   <= base_d;
			sum_q    <= sum_d;
			start_q  <= start_d;
			end_q    <= end_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res_valid;
		end
	end

	// hold the result beat while stalled
	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			kind_q <= res_kind;
			addr_q <= res_addr;
			byte_q <= res_byte;
			ok_q   <= res_ok;
			low_q  <= (res_kind == KIND_END) ? start_d : 1'b0;
			high_q <= (res_kind == KIND_END) ? end_d : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign write_address = addr_q;
	assign write_byte    = byte_q;
	assign checksum_ok   = ok_q;
	assign lowest_start  = {15'd0, low_q};
	assign highest_end   = high_q;

	`IHEX_ASSERT_ALWAYS(a_data_has_bytes, (phase_q != PH_DATA) || (left_q != 8'd0), "data phase with no bytes left")
	`IHEX_ASSERT_NEXT(a_start_stays_low, !start_q, !start_q, "lowest start rose after dropping to zero")
	`IHEX_ASSERT_ALWAYS(a_stall_needs_beat, !in_stall || (valid_s1 && out_valid_q), "input stalled with no pending beat")
	`IHEX_ASSERT_ALWAYS(a_write_no_bounds, !out_valid_q || (kind_q == KIND_END) || ((high_q == '0) && !low_q && !ok_q), "write beat carries record-end fields")
	`IHEX_ASSERT_NEXT(a_end_to_hunt, fire && res_valid && (res_kind == KIND_END), phase_q == PH_HUNT, "parser not hunting after record end")

endmodule

>>> bench/ihex_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record parser checker
// Watches both channels, follows every taken character through its own copy
// of the record parser and compares each result beat field by field with the
// oldest predicted beat.
// ----------------------------------------------------------------------------
module ihex_record_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [7:0]                   character,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         result_kind,
	input  logic [ihex_pkg::ADDR_W-1:0]  write_address,
	input  logic [7:0]                   write_byte,
	input  logic                         checksum_ok,
	input  logic [15:0]                  lowest_start,
	input  logic [ihex_pkg::ADDR_W-1:0]  highest_end,
	output int                           fail_count,
	output int                           pending
);
	import ihex_pkg::*;

	typedef struct {
		result_kind_t        kind;
		logic [ADDR_W-1:0]   addr;
		logic [7:0]          data;
		logic                sum_ok;
		logic [15:0]         low;
		logic [ADDR_W-1:0]   high;
	} parse_beat_t;

	parse_beat_t expected_beats[$];

	// parser copy
	phase_t              phase;
	logic [2:0]          digits_taken;
	logic [15:0]         field_accum;
	bit                  field_ended;
	logic [7:0]          bytes_left;
	logic [ADDR_W-1:0]   cursor;
	logic [15:0]         record_base;
	logic [7:0]          running_sum;
	logic [ADDR_W-1:0]   start_tracker;
	logic [ADDR_W-1:0]   end_tracker;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (fail_count < 40) begin
			$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		end
		fail_count++;
	endtask

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= ASCII_ZERO && c <= ASCII_NINE) return int'(c - ASCII_ZERO);
		if (c >= UPPER_A && c <= UPPER_F) return int'(c - UPPER_A) + 10;
		if (c >= LOWER_A && c <= LOWER_F) return int'(c - LOWER_A) + 10;
		return -1;
	endfunction

	// Take one character of a fixed-width field; a non-hex character freezes
	// the value but still uses up a position.
	task automatic field_step(input logic [7:0] c, input int width, output bit done,
			output logic [15:0] value);
		int nib;
		nib = nibble_of(c);
		if (!field_ended && nib >= 0) begin
			field_accum = {field_accum[11:0], nib[3:0]};
		end else begin
			field_ended = 1'b1;
		end
		digits_taken = digits_taken + 3'd1;
		done = (digits_taken >= width);
		value = field_accum;
		if (done) begin
			digits_taken = '0;
			field_accum = '0;
			field_ended = 1'b0;
		end
	endtask

	task automatic parse_char(input logic [7:0] c);
		bit done;
		logic [15:0] v;
		parse_beat_t beat;
		beat.kind = KIND_DATA;
		beat.addr = '0;
		beat.data = '0;
		beat.sum_ok = 1'b0;
		beat.low = '0;
		beat.high = '0;
		case (phase)
			PH_LEN: begin
				field_step(c, 2, done, v);
				if (done) begin
					bytes_left = v[7:0];
					running_sum = v[7:0];
					phase = PH_ADDR;
				end
			end
			PH_ADDR: begin
				field_step(c, 4, done, v);
				if (done) begin
					record_base = v;
					cursor = {1'b0, v};
					running_sum = running_sum + v[15:8] + v[7:0];
					phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				field_step(c, 2, done, v);
				if (done) begin
					running_sum = running_sum + v[7:0];
					if (v != 16'd0) phase = PH_HUNT;
					else if (bytes_left == 8'd0) phase = PH_CSUM;
					else phase = PH_DATA;
				end
			end
			PH_DATA: begin
				field_step(c, 2, done, v);
				if (done) begin
					beat.addr = cursor;
					beat.data = v[7:0];
					expected_beats.push_back(beat);
					cursor = cursor + ADDR_W'(1);
					running_sum = running_sum + v[7:0];
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 8'd0) phase = PH_CSUM;
				end
			end
			PH_CSUM: begin
				field_step(c, 2, done, v);
				if (done) begin
					running_sum = running_sum + v[7:0];
					if (start_tracker > {1'b0, record_base}) start_tracker = {1'b0, record_base};
					if (end_tracker < cursor) end_tracker = cursor;
					beat.kind = KIND_END;
					beat.sum_ok = (running_sum == 8'd0);
					beat.low = start_tracker[15:0];
					beat.high = end_tracker;
					expected_beats.push_back(beat);
					phase = PH_HUNT;
				end
			end
			default: begin
				if (c == COLON_CHAR) begin
					digits_taken = '0;
					field_accum = '0;
					field_ended = 1'b0;
					phase = PH_LEN;
				end else begin
					phase = PH_HUNT;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_HUNT;
			digits_taken = '0;
			field_accum = '0;
			field_ended = 1'b0;
			bytes_left = '0;
			cursor = '0;
			record_base = '0;
			running_sum = '0;
			start_tracker = 17'd1;
			end_tracker = '0;
			expected_beats.delete();
		end else begin
			// a result beat always comes from a character taken at an earlier edge
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("result beat with nothing pending, kind",
						32'(result_kind), 32'd0);
				end else begin
					parse_beat_t want;
					want = expected_beats.pop_front();
					if (result_kind !== want.kind)
						report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
					if (write_address !== want.addr)
						report_mismatch("write_address", 32'(write_address), 32'(want.addr));
					if (write_byte !== want.data)
						report_mismatch("write_byte", 32'(write_byte), 32'(want.data));
					if (checksum_ok !== want.sum_ok)
						report_mismatch("checksum_ok", 32'(checksum_ok), 32'(want.sum_ok));
					if (lowest_start !== want.low)
						report_mismatch("lowest_start", 32'(lowest_start), 32'(want.low));
					if (highest_end !== want.high)
						report_mismatch("highest_end", 32'(highest_end), 32'(want.high));
				end
			end
			if (in_valid && !in_stall) parse_char(character);
		end
		pending = expected_beats.size();
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record parser testbench
// Streams short directed records and then random record traffic (data and
// other record types, bad checksums, non-hex characters inside fields, line
// noise) through the parser with random gaps and stalls on both channels,
// and lets the checker compare every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	import ihex_pkg::*;

	localparam int TARGET_CHARS    = 1550;
	localparam int PRESSURE_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 4000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           character;
	logic                 out_valid;
	logic                 out_stall;
	logic                 result_kind;
	logic [ADDR_W-1:0]    write_address;
	logic [7:0]           write_byte;
	logic                 checksum_ok;
	logic [15:0]          lowest_start;
	logic [ADDR_W-1:0]    highest_end;

	int fail_count;
	int pending;
	int chars_taken;
	int idle_cycles;
	bit calm;

	intel_hex_record_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.character     (character),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.write_address (write_address),
		.write_byte    (write_byte),
		.checksum_ok   (checksum_ok),
		.lowest_start  (lowest_start),
		.highest_end   (highest_end)
	);

	ihex_record_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.character     (character),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.write_address (write_address),
		.write_byte    (write_byte),
		.checksum_ok   (checksum_ok),
		.lowest_start  (lowest_start),
		.highest_end   (highest_end),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly short idle stretches, now and then a long one
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		character <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		chars_taken++;
	endtask

	// Send a hex field, random letter case; a noisy field may carry non-hex junk.
	task automatic send_field(input logic [15:0] value, input int digits, input bit noisy);
		logic [3:0] nib;
		logic [7:0] c;
		for (int i = digits - 1; i >= 0; i--) begin
			nib = value[4*i +: 4];
			if (noisy && $urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0:       c = 8'($urandom_range(8'h00, 8'h2F));
					1:       c = 8'($urandom_range(8'h3A, 8'h40));
					2:       c = 8'($urandom_range(8'h47, 8'h60));
					default: c = 8'($urandom_range(8'h67, 8'hFF));
				endcase
			end else if (nib < 4'd10) begin
				c = ASCII_ZERO + nib;
			end else if ($urandom_range(0, 1)) begin
				c = UPPER_A + nib - 4'd10;
			end else begin
				c = LOWER_A + nib - 4'd10;
			end
			send_char(c);
		end
	endtask

	task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
			input logic [7:0] rtype, input bit good_sum, input bit noisy);
		logic [7:0] sum;
		logic [7:0] b;
		sum = len + addr[15:8] + addr[7:0] + rtype;
		send_char(COLON_CHAR);
		send_field({8'd0, len}, 2, noisy);
		send_field(addr, 4, noisy);
		send_field({8'd0, rtype}, 2, noisy);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			sum = sum + b;
			send_field({8'd0, b}, 2, noisy);
		end
		if (good_sum) send_field({8'd0, 8'd0 - sum}, 2, noisy);
		else send_field({8'd0, 8'd0 - sum + 8'($urandom_range(1, 255))}, 2, noisy);
	endtask

	initial begin
		int rec;
		int n;
		logic [7:0] len;
		logic [15:0] addr;
		logic [7:0] rtype;
		in_valid = 1'b0;
		character = '0;
		arst_n = 1'b0;
		chars_taken = 0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one byte at the top address, then an empty data record at zero with a bad sum
		send_record(8'd1, 16'hFFFF, 8'd0, 1'b1, 1'b0);
		send_record(8'd0, 16'h0000, 8'd0, 1'b0, 1'b0);

		rec = 0;
		while (chars_taken < TARGET_CHARS) begin
			calm = ($urandom_range(0, 9) < 2);
			n = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
			for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)));
			if (rec == 10) begin
				// longest record at the top of the address space
				send_record(8'hFF, 16'hFFFF, 8'd0, 1'b1, 1'b0);
			end else begin
				len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 40))
					: 8'($urandom_range(0, 16));
				case ($urandom_range(0, 19))
					0, 1:    addr = 16'h0000;
					2, 3, 4: addr = 16'($urandom_range(16'hFFC0, 16'hFFFF));
					default: addr = 16'($urandom_range(0, 16'hFFFF));
				endcase
				case ($urandom_range(0, 9))
					0:       rtype = 8'($urandom_range(1, 5));
					1:       rtype = 8'($urandom_range(1, 255));
					default: rtype = 8'd0;
				endcase
				send_record(len, addr, rtype, $urandom_range(0, 99) < 85,
					$urandom_range(0, 9) == 0);
			end
			if ($urandom_range(0, 1)) begin
				send_char(8'h0D);
				send_char(8'h0A);
			end
			rec++;
		end
		in_valid <= 1'b0;

		// let the checker see the last taken beat before draining
		@(posedge clk);
		wait (pending == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	// result side: random stalls, and once a long hold so the parser backs up
	initial begin
		int hold;
		bit pressed;
		pressed = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!pressed && chars_taken >= 400) begin
				pressed = 1'b1;
				out_stall <= 1'b1;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			hold = pick_idle();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
